// ----- sv/keyframe_fade_envelope_unit_defines.svh -----
// assertion macros for the keyframe fade envelope unit
// no dependencies; included by the modules that carry assertions
`ifndef KEYFRAME_FADE_ENVELOPE_UNIT_DEFINES_SVH
`define KEYFRAME_FADE_ENVELOPE_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define KFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfe assertion failed");
// next-cycle implication, disabled during reset
`define KFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfe assertion failed");
`else
`define KFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/kfe_pkg.sv -----
// shared types and constants of the keyframe fade envelope unit
// no dependencies
`timescale 1ns / 1ps

package kfe_pkg;

    // default configuration
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ALPHA_BITS_DEF  = 16;

    // fixed field widths
    localparam int FIELD_W     = 32;
    localparam int IN_ALPHA_W  = 16;
    localparam int OUT_ALPHA_W = 16;

    // request opcodes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // breakpoint queue control
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    // breakpoint queue status
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- sv/keyframe_fade_envelope_unit.sv -----
// top level of the keyframe fade envelope: sequencer, previous point, clamp
// depends on kfe_pkg, kfe_queue, kfe_div and keyframe_fade_envelope_unit_defines.svh
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+------------------------
//  request  | i_op i_point_field i_point_alpha i_render_field | start & !busy
//  result   | o_alpha_out                                    | o_valid, one cycle
//
// an add request pushes the point straight into the fifo and busy stays low
// a render reads the fifo once per popped point, then either returns the previous
// alpha or runs the two-bit-per-cycle divider to interpolate toward the next point
// reset is synchronous; the fifo memory is not cleared and needs no pass
// the result strobe cannot be stalled; busy falls with it
`timescale 1ns / 1ps
`include "keyframe_fade_envelope_unit_defines.svh"

module keyframe_fade_envelope_unit import kfe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ALPHA_BITS  = ALPHA_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_op,
    input  logic [FIELD_W-1:0]     i_point_field,
    input  logic [IN_ALPHA_W-1:0]  i_point_alpha,
    input  logic [FIELD_W-1:0]     i_render_field,
    output logic                   o_valid,
    output logic [OUT_ALPHA_W-1:0] o_alpha_out
);

    localparam int AW = ALPHA_BITS;
    localparam int PW = FIELD_W + AW;
    localparam logic [AW-1:0] ALPHA_MAX = {AW{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_busy, n_busy;
    logic                   r_valid, n_valid;
    logic [OUT_ALPHA_W-1:0] r_alpha_out, n_alpha_out;
    logic [FIELD_W-1:0]     r_prev_field, n_prev_field;
    logic [AW-1:0]          r_prev_alpha, n_prev_alpha;
    logic                   r_prev_valid, n_prev_valid;
    logic [FIELD_W-1:0]     r_rf, n_rf;
    logic                   r_rel_neg, n_rel_neg;
    logic                   r_da_neg, n_da_neg;
    logic [FIELD_W-1:0]     r_mag_rel, n_mag_rel;
    logic [AW-1:0]          r_mag_da, n_mag_da;
    logic [FIELD_W-1:0]     r_span, n_span;
    logic                   r_div_start, n_div_start;

    t_q_ctrl                q_ctrl;
    t_q_stat                q_stat;
    logic [FIELD_W-1:0]     rd_field;
    logic [AW-1:0]          rd_alpha;
    logic                   div_done;
    logic [PW-1:0]          div_quot;

    logic                   w_accept;
    logic [AW+IN_ALPHA_W-1:0] w_pa_ext;
    logic [AW-1:0]          w_pa;
    logic [AW-1:0]          w_interp;
    logic [AW-1:0]          w_room;
    logic [OUT_ALPHA_W+AW-1:0] w_out_prev_ext, w_out_interp_ext;

    assign w_accept = start && !r_busy;
    assign w_pa_ext = {{AW{1'b0}}, i_point_alpha};
    assign w_pa     = w_pa_ext[AW-1:0];

    // breakpoint fifo
    kfe_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ALPHA_BITS  (ALPHA_BITS)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (q_ctrl),
        .i_wr_field (i_point_field),
        .i_wr_alpha (w_pa),
        .o_stat     (q_stat),
        .o_rd_field (rd_field),
        .o_rd_alpha (rd_alpha)
    );

    // shared multiply/divide unit
    kfe_div #(
        .ALPHA_BITS (ALPHA_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_mag_rel (r_mag_rel),
        .i_mag_da  (r_mag_da),
        .i_span    (r_span),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // apply the signed quotient to the previous alpha with saturation
    always_comb begin
        w_room = ALPHA_MAX - r_prev_alpha;
        if (r_rel_neg ^ r_da_neg) begin
            if (div_quot > {{FIELD_W{1'b0}}, r_prev_alpha}) begin
                w_interp = '0;
            end else begin
                w_interp = r_prev_alpha - div_quot[AW-1:0];
            end
        end else begin
            if (div_quot > {{FIELD_W{1'b0}}, w_room}) begin
                w_interp = ALPHA_MAX;
            end else begin
                w_interp = r_prev_alpha + div_quot[AW-1:0];
            end
        end
    end

    assign w_out_prev_ext   = {{OUT_ALPHA_W{1'b0}}, r_prev_alpha};
    assign w_out_interp_ext = {{OUT_ALPHA_W{1'b0}}, w_interp};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_valid      = 1'b0;
        n_alpha_out  = r_alpha_out;
        n_prev_field = r_prev_field;
        n_prev_alpha = r_prev_alpha;
        n_prev_valid = r_prev_valid;
        n_rf         = r_rf;
        n_rel_neg    = r_rel_neg;
        n_da_neg     = r_da_neg;
        n_mag_rel    = r_mag_rel;
        n_mag_da     = r_mag_da;
        n_span       = r_span;
        n_div_start  = 1'b0;
        q_ctrl.push  = 1'b0;
        q_ctrl.pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_ADD) begin
                        if (!q_stat.full) begin
                            q_ctrl.push = 1'b1;
                            if (!r_prev_valid) begin
                                n_prev_field = i_point_field;
                                n_prev_alpha = w_pa;
                                n_prev_valid = 1'b1;
                            end
                        end
                    end else begin
                        n_rf    = i_render_field;
                        n_busy  = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!q_stat.empty && (rd_field <= r_rf)) begin
                    // pop a passed breakpoint
                    q_ctrl.pop   = 1'b1;
                    n_prev_field = rd_field;
                    n_prev_alpha = rd_alpha;
                    n_prev_valid = 1'b1;
                    n_state      = S_READ;
                end else if (!q_stat.empty && (rd_field > r_prev_field)) begin
                    // set up magnitudes and signs for the divider
                    n_rel_neg   = (r_rf < r_prev_field);
                    n_mag_rel   = n_rel_neg ? r_prev_field - r_rf : r_rf - r_prev_field;
                    n_da_neg    = (rd_alpha < r_prev_alpha);
                    n_mag_da    = n_da_neg ? r_prev_alpha - rd_alpha : rd_alpha - r_prev_alpha;
                    n_span      = rd_field - r_prev_field;
                    n_div_start = 1'b1;
                    n_state     = S_WAIT;
                end else begin
                    // hold the previous alpha
                    n_alpha_out = w_out_prev_ext[OUT_ALPHA_W-1:0];
                    n_valid     = 1'b1;
                    n_busy      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_alpha_out = w_out_interp_ext[OUT_ALPHA_W-1:0];
                n_valid     = 1'b1;
                n_busy      = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= 1'b0;
            r_valid      <= 1'b0;
            r_prev_field <= '0;
            r_prev_alpha <= ALPHA_MAX;
            r_prev_valid <= 1'b0;
            r_div_start  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy       <= n_busy;
            r_valid      <= n_valid;
            r_prev_field <= n_prev_field;
            r_prev_alpha <= n_prev_alpha;
            r_prev_valid <= n_prev_valid;
            r_div_start  <= n_div_start;
        end
        r_alpha_out <= n_alpha_out;
        r_rf        <= n_rf;
        r_rel_neg   <= n_rel_neg;
        r_da_neg    <= n_da_neg;
        r_mag_rel   <= n_mag_rel;
        r_mag_da    <= n_mag_da;
        r_span      <= n_span;
    end

    assign busy        = r_busy;
    assign o_valid     = r_valid;
    assign o_alpha_out = r_alpha_out;

    // checks on sequencing between the fifo, divider and result strobe
    `KFE_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, q_ctrl.pop, !q_stat.empty)
    `KFE_ASSERT_IMPL(a_push_idle, i_clk, i_rst_n, q_ctrl.push, !r_busy && !q_stat.full)
    `KFE_ASSERT_IMPL(a_strobe_after_busy, i_clk, i_rst_n, r_valid, $past(r_busy))
    `KFE_ASSERT_IMPL(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == S_WAIT)
    `KFE_ASSERT_NEXT(a_pop_rereads, i_clk, i_rst_n, q_ctrl.pop, r_state == S_READ)

endmodule

// ----- sv/kfe_queue.sv -----
// breakpoint fifo: circular memory of field/alpha pairs with head and count
// depends on kfe_pkg
`timescale 1ns / 1ps

module kfe_queue import kfe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ALPHA_BITS  = ALPHA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_q_ctrl               i_ctrl,
    input  logic [FIELD_W-1:0]    i_wr_field,
    input  logic [ALPHA_BITS-1:0] i_wr_alpha,
    output t_q_stat               o_stat,
    output logic [FIELD_W-1:0]    o_rd_field,
    output logic [ALPHA_BITS-1:0] o_rd_alpha
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [FIELD_W-1:0]    r_mem_field [QUEUE_DEPTH];
    logic [ALPHA_BITS-1:0] r_mem_alpha [QUEUE_DEPTH];
    logic [IW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         n_head;
    logic [CW-1:0]         n_count;
    logic [CW:0]           w_tail_sum;
    logic [IW-1:0]         w_tail;

    // write position, wrapped at the depth
    always_comb begin
        w_tail_sum = {{(CW + 1 - IW){1'b0}}, r_head} + {1'b0, r_count};
        if (w_tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            w_tail_sum = w_tail_sum - (CW + 1)'(QUEUE_DEPTH);
        end
        w_tail = w_tail_sum[IW-1:0];
    end

    // head and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            n_count = r_count - 1'b1;
            n_head  = (r_head == IW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem_field[w_tail] <= i_wr_field;
            r_mem_alpha[w_tail] <= i_wr_alpha;
        end
    end

    // registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        o_rd_field <= r_mem_field[r_head];
        o_rd_alpha <= r_mem_alpha[r_head];
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(QUEUE_DEPTH));

endmodule

// ----- sv/kfe_div.sv -----
// shared multiply then radix-4 restoring divide of magnitudes
// depends on kfe_pkg; operands must hold steady from start until done
`timescale 1ns / 1ps

module kfe_div import kfe_pkg::*; #(
    parameter int ALPHA_BITS = ALPHA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [FIELD_W-1:0]            i_mag_rel,
    input  logic [ALPHA_BITS-1:0]         i_mag_da,
    input  logic [FIELD_W-1:0]            i_span,
    output logic                          o_done,
    output logic [FIELD_W+ALPHA_BITS-1:0] o_quot
);

    localparam int PW    = FIELD_W + ALPHA_BITS;
    localparam int DW    = PW + (PW % 2);
    localparam int STEPS = DW / 2;
    localparam int SCW   = $clog2(STEPS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

    t_state             r_state, n_state;
    logic [DW-1:0]      r_num, n_num;
    logic [FIELD_W-1:0] r_rem, n_rem;
    logic [SCW-1:0]     r_cnt, n_cnt;
    logic               n_done;
    logic [PW-1:0]      w_prod;
    logic [FIELD_W:0]   w_t1, w_t2, w_den;
    logic               w_ge1, w_ge2;
    logic [FIELD_W:0]   w_rem1, w_rem2;

    assign w_prod = {{ALPHA_BITS{1'b0}}, i_mag_rel} * {{FIELD_W{1'b0}}, i_mag_da};
    assign w_den  = {1'b0, i_span};

    // two restoring steps per cycle
    always_comb begin
        w_t1   = {r_rem, r_num[DW-1]};
        w_ge1  = (w_t1 >= w_den);
        w_rem1 = w_ge1 ? w_t1 - w_den : w_t1;
        w_t2   = {w_rem1[FIELD_W-1:0], r_num[DW-2]};
        w_ge2  = (w_t2 >= w_den);
        w_rem2 = w_ge2 ? w_t2 - w_den : w_t2;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_num   = DW'(w_prod);
                n_rem   = '0;
                n_cnt   = SCW'(STEPS);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_num = {r_num[DW-3:0], w_ge1, w_ge2};
                n_rem = w_rem2[FIELD_W-1:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == SCW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            o_done  <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_quot = r_num[PW-1:0];

endmodule
